// File: design/iga_pkg.sv
package iga_pkg;

  localparam int TW        = 48;
  localparam int AXW       = 16;
  localparam int XYZW      = 3 * AXW;
  localparam int PRODW     = AXW + TW + 1;
  localparam int NUMW      = PRODW + 1;
  localparam int MAGW      = 64;
  localparam int DIV_STEPS = 16;
  localparam int DCW       = 4;

  localparam logic SENSOR_ACCEL = 1'b0;
  localparam logic SENSOR_GYRO  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CLS,
    ST_DIFF,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_EMIT,
    ST_FLUSH
  } iga_state_t;

  typedef struct packed {
    logic acc_load;
    logic gyro_take;
    logic q_push;
    logic ovf_set;
    logic scan_init;
    logic rd_issue;
    logic scan_adv;
    logic ent_take;
    logic keep_wr;
    logic scan_done;
    logic diff;
    logic mul;
    logic sum;
    logic div_step;
    logic emit;
    logic flush;
  } iga_cmd_t;

  typedef struct packed {
    logic en;
    logic is_gyro;
    logic count_nz;
    logic bracket;
    logic newer;
    logic q_full;
    logic drain_go;
    logic scan_more;
    logic ent_emit;
    logic ent_keep;
    logic div_last;
    logic emit_ok;
  } iga_status_t;

  typedef struct packed {
    logic [TW-1:0]  time_v;
    logic [AXW-1:0] ax;
    logic [AXW-1:0] ay;
    logic [AXW-1:0] az;
    logic [AXW-1:0] gx;
    logic [AXW-1:0] gy;
    logic [AXW-1:0] gz;
    logic           lost;
  } iga_res_t;

endpackage

// File: design/imu_gyro_aligned_accel_interpolator.sv
// imu accel/gyro aligner with linear accel interpolation at gyro time
//
// channels: in_* carries one accel (in_sensor 0) or gyro (in_sensor 1) sample
// per transfer; out_* carries one combined sample per transfer; cfg_* writes
// the enable bit (cfg_ready is always high). all use valid/ready.
// usage: write enable, then stream samples. a gyro inside the accel bracket
// yields one result; an accel drains every queued gyro it now brackets, the
// run ending with out_last high. out_lost_gyro flags queue overflow drops.
// flow: a gyro inside the bracket passes difference, multiply, sum, a 16-step
// restoring divide run in parallel by the three axis lanes, emit and flush;
// its result shows on out_valid as in_ready returns. a drain reads and checks
// each queued entry, runs those steps per emitted result, then flushes; a
// queued or dropped gyro, or an accel with nothing to drain, is taken in idle.
// the block works on one input at a time: in_ready is high only when idle,
// but a finished result waiting in the output register does not block it.
// a receiver stall holds the pending result and pauses the drain sequence.
// reset (rst_n low, synchronous) clears enable, the accel bracket, the queue
// count and the overflow flag; queue storage needs no clearing.
module imu_gyro_aligned_accel_interpolator #(
  parameter int GYRO_QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_enable,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_sensor,
  input  logic [47:0] in_timestamp,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_sample_time,
  output logic signed [15:0] out_accel_x,
  output logic signed [15:0] out_accel_y,
  output logic signed [15:0] out_accel_z,
  output logic signed [15:0] out_gyro_x,
  output logic signed [15:0] out_gyro_y,
  output logic signed [15:0] out_gyro_z,
  output logic        out_last,
  output logic        out_lost_gyro
);

  iga_pkg::iga_cmd_t    cmd;
  iga_pkg::iga_status_t st;
  iga_pkg::iga_res_t    res;

  // config writes are taken at any time
  assign cfg_ready = 1'b1;

  iga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_sensor(in_sensor),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // the last flag lives with the output register inside the datapath
  iga_dp #(.GYRO_QUEUE_DEPTH(GYRO_QUEUE_DEPTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_enable  (cfg_enable),
    .in_sensor   (in_sensor),
    .in_timestamp(in_timestamp),
    .in_axis_x   (in_axis_x),
    .in_axis_y   (in_axis_y),
    .in_axis_z   (in_axis_z),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_res     (res),
    .out_last    (out_last)
  );

  assign out_sample_time = res.time_v;
  assign out_accel_x     = res.ax;
  assign out_accel_y     = res.ay;
  assign out_accel_z     = res.az;
  assign out_gyro_x      = res.gx;
  assign out_gyro_y      = res.gy;
  assign out_gyro_z      = res.gz;
  assign out_lost_gyro   = res.lost;

endmodule

// File: design/iga_ram.sv
module iga_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: design/iga_ctrl.sv
module iga_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_sensor,
  input  iga_pkg::iga_status_t st,
  output logic                 in_ready,
  output iga_pkg::iga_cmd_t    cmd
);

  iga_pkg::iga_state_t state_r, state_nxt;
  logic drain_r, drain_nxt;
  logic take;

  assign take = in_valid && (state_r == iga_pkg::ST_IDLE) && st.en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iga_pkg::ST_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    case (state_r)
      iga_pkg::ST_IDLE: begin
        if (take) begin
          if (in_sensor == iga_pkg::SENSOR_ACCEL) begin
            drain_nxt = 1'b1;
            if (st.drain_go) state_nxt = iga_pkg::ST_RD;
          end else begin
            drain_nxt = 1'b0;
            if (st.bracket) state_nxt = iga_pkg::ST_DIFF;
          end
        end
      end
      iga_pkg::ST_RD:    state_nxt = st.scan_more ? iga_pkg::ST_CLS : iga_pkg::ST_FLUSH;
      iga_pkg::ST_CLS:   state_nxt = st.ent_emit ? iga_pkg::ST_DIFF : iga_pkg::ST_RD;
      iga_pkg::ST_DIFF:  state_nxt = iga_pkg::ST_MUL;
      iga_pkg::ST_MUL:   state_nxt = iga_pkg::ST_SUM;
      iga_pkg::ST_SUM:   state_nxt = iga_pkg::ST_DIV;
      iga_pkg::ST_DIV:   if (st.div_last) state_nxt = iga_pkg::ST_EMIT;
      iga_pkg::ST_EMIT: begin
        if (st.emit_ok) state_nxt = drain_r ? iga_pkg::ST_RD : iga_pkg::ST_FLUSH;
      end
      iga_pkg::ST_FLUSH: if (st.emit_ok) state_nxt = iga_pkg::ST_IDLE;
      default:           state_nxt = iga_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = (state_r == iga_pkg::ST_IDLE);
    case (state_r)
      iga_pkg::ST_IDLE: begin
        if (take) begin
          if (in_sensor == iga_pkg::SENSOR_ACCEL) begin
            cmd.acc_load  = 1'b1;
            cmd.scan_init = 1'b1;
          end else if (st.count_nz) begin
            if (st.bracket) begin
              cmd.gyro_take = 1'b1;
            end else if (st.newer) begin
              cmd.ovf_set = st.q_full;
              cmd.q_push  = !st.q_full;
            end
          end
        end
      end
      iga_pkg::ST_RD: begin
        cmd.rd_issue  = st.scan_more;
        cmd.scan_done = !st.scan_more;
      end
      iga_pkg::ST_CLS: begin
        cmd.scan_adv = 1'b1;
        cmd.ent_take = st.ent_emit;
        cmd.keep_wr  = st.ent_keep;
      end
      iga_pkg::ST_DIFF:  cmd.diff     = 1'b1;
      iga_pkg::ST_MUL:   cmd.mul      = 1'b1;
      iga_pkg::ST_SUM:   cmd.sum      = 1'b1;
      iga_pkg::ST_DIV:   cmd.div_step = 1'b1;
      iga_pkg::ST_EMIT:  cmd.emit     = st.emit_ok;
      iga_pkg::ST_FLUSH: cmd.flush    = st.emit_ok;
      default: ;
    endcase
  end

endmodule

// File: design/iga_dp.sv
module iga_dp #(
  parameter int GYRO_QUEUE_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic                        cfg_enable,
  input  logic                        in_sensor,
  input  logic [iga_pkg::TW-1:0]      in_timestamp,
  input  logic signed [iga_pkg::AXW-1:0] in_axis_x,
  input  logic signed [iga_pkg::AXW-1:0] in_axis_y,
  input  logic signed [iga_pkg::AXW-1:0] in_axis_z,
  input  logic                        out_ready,
  input  iga_pkg::iga_cmd_t           cmd,
  output iga_pkg::iga_status_t        st,
  output logic                        out_valid,
  output iga_pkg::iga_res_t           out_res,
  output logic                        out_last
);

  localparam int AW = $clog2(GYRO_QUEUE_DEPTH);
  localparam int CW = $clog2(GYRO_QUEUE_DEPTH + 1);
  localparam int TW = iga_pkg::TW;
  localparam int AXW = iga_pkg::AXW;
  localparam int XYZW = iga_pkg::XYZW;
  localparam int EW = TW + XYZW;

  logic enable_r;
  logic [TW-1:0] t0_r, t1_r;
  logic [XYZW-1:0] a0xyz_r, a1xyz_r;
  logic [1:0] acount_r;
  logic [CW-1:0] pc_r, i_r, w_r;
  logic ovf_r;
  logic [TW-1:0] wt_r;
  logic [XYZW-1:0] wg_r;
  logic [TW-1:0] d0_r, d1_r, span_r;
  logic zero_r;
  logic signed [iga_pkg::PRODW-1:0] p0_r [3];
  logic signed [iga_pkg::PRODW-1:0] p1_r [3];
  logic [TW-1:0] rem_r [3];
  logic [AXW-1:0] q_r [3];
  logic neg_r [3];
  logic [iga_pkg::DCW-1:0] dcnt_r;
  iga_pkg::iga_res_t hold_r, out_r;
  logic hold_v_r, out_valid_r;

  logic [XYZW-1:0] in_xyz;
  logic [EW-1:0] rdata, wdata;
  logic [TW-1:0] gt;
  logic we;
  logic [AW-1:0] waddr;
  logic out_free, load_out;
  logic signed [AXW-1:0] a0 [3];
  logic signed [AXW-1:0] a1 [3];
  logic [AXW-1:0] res [3];

  assign in_xyz = {in_axis_z, in_axis_y, in_axis_x};
  assign gt     = rdata[EW-1:XYZW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a0[k]  = a0xyz_r[AXW*k +: AXW];
      a1[k]  = a1xyz_r[AXW*k +: AXW];
      res[k] = zero_r ? a1xyz_r[AXW*k +: AXW] : (neg_r[k] ? -q_r[k] : q_r[k]);
    end
  end

  // gyro queue
  assign we    = cmd.q_push || cmd.keep_wr;
  assign waddr = cmd.q_push ? pc_r[AW-1:0] : w_r[AW-1:0];
  assign wdata = cmd.q_push ? {in_timestamp, in_xyz} : rdata;

  iga_ram #(.WIDTH(EW), .DEPTH(GYRO_QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (cmd.rd_issue),
    .raddr  (i_r[AW-1:0]),
    .rdata_r(rdata)
  );

  assign out_free = !out_valid_r || out_ready;
  assign load_out = (cmd.emit || cmd.flush) && hold_v_r;

  always_comb begin
    st           = '0;
    st.en        = enable_r;
    st.is_gyro   = (in_sensor == iga_pkg::SENSOR_GYRO);
    st.count_nz  = (acount_r != 2'd0);
    st.bracket   = (acount_r == 2'd2) && (t0_r <= in_timestamp) && (in_timestamp <= t1_r);
    st.newer     = (in_timestamp > t1_r);
    st.q_full    = (pc_r == CW'(GYRO_QUEUE_DEPTH));
    st.drain_go  = (acount_r != 2'd0) && (pc_r != '0);
    st.scan_more = (i_r < pc_r);
    st.ent_emit  = (gt >= t0_r) && (gt <= t1_r);
    // entries older than the older accel are dropped even when the bracket is inverted
    st.ent_keep  = (gt >= t0_r) && (gt > t1_r);
    st.div_last  = (dcnt_r == iga_pkg::DCW'(iga_pkg::DIV_STEPS - 1));
    st.emit_ok   = !hold_v_r || out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      t0_r        <= '0;
      t1_r        <= '0;
      a0xyz_r     <= '0;
      a1xyz_r     <= '0;
      acount_r    <= '0;
      pc_r        <= '0;
      i_r         <= '0;
      w_r         <= '0;
      ovf_r       <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) enable_r <= cfg_enable;
      if (cmd.acc_load) begin
        t0_r    <= t1_r;
        a0xyz_r <= a1xyz_r;
        t1_r    <= in_timestamp;
        a1xyz_r <= in_xyz;
        if (acount_r != 2'd2) acount_r <= acount_r + 2'd1;
      end
      if (cmd.q_push) pc_r <= pc_r + CW'(1);
      if (cmd.ovf_set) ovf_r <= 1'b1;
      if (cmd.scan_init) begin
        i_r <= '0;
        w_r <= '0;
      end
      if (cmd.scan_adv) i_r <= i_r + CW'(1);
      if (cmd.keep_wr) w_r <= w_r + CW'(1);
      if (cmd.scan_done) pc_r <= w_r;
      if (cmd.emit) begin
        hold_r   <= '{time_v: wt_r, ax: res[0], ay: res[1], az: res[2],
                      gx: wg_r[AXW-1:0], gy: wg_r[2*AXW-1:AXW],
                      gz: wg_r[XYZW-1:2*AXW], lost: ovf_r};
        hold_v_r <= 1'b1;
        ovf_r    <= 1'b0;
      end else if (cmd.flush) begin
        hold_v_r <= 1'b0;
      end
      if (load_out) begin
        out_r       <= hold_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // last flag only on the flush of the final held result
  logic out_last_r;
  always_ff @(posedge clk) begin
    if (load_out) out_last_r <= cmd.flush;
  end

  // interpolation datapath: diff, multiply, sum, restoring divide per lane
  always_ff @(posedge clk) begin
    if (cmd.gyro_take) begin
      wt_r <= in_timestamp;
      wg_r <= in_xyz;
    end else if (cmd.ent_take) begin
      wt_r <= gt;
      wg_r <= rdata[XYZW-1:0];
    end
    if (cmd.diff) begin
      d1_r   <= t1_r - wt_r;
      d0_r   <= wt_r - t0_r;
      span_r <= t1_r - t0_r;
      zero_r <= (t1_r == t0_r);
    end
    if (cmd.mul) begin
      for (int k = 0; k < 3; k++) begin
        p0_r[k] <= a0[k] * $signed({1'b0, d1_r});
        p1_r[k] <= a1[k] * $signed({1'b0, d0_r});
      end
    end
    if (cmd.sum) begin
      dcnt_r <= '0;
      for (int k = 0; k < 3; k++) begin
        logic signed [iga_pkg::NUMW-1:0] num;
        logic [iga_pkg::NUMW-1:0] mag;
        num = {p0_r[k][iga_pkg::PRODW-1], p0_r[k]} + {p1_r[k][iga_pkg::PRODW-1], p1_r[k]};
        mag = num[iga_pkg::NUMW-1] ? -num : num;
        neg_r[k] <= num[iga_pkg::NUMW-1];
        rem_r[k] <= mag[iga_pkg::MAGW-1:AXW];
        q_r[k]   <= mag[AXW-1:0];
      end
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + iga_pkg::DCW'(1);
      for (int k = 0; k < 3; k++) begin
        logic [TW:0] part;
        logic ge;
        part = {rem_r[k], q_r[k][AXW-1]};
        ge   = (part >= {1'b0, span_r});
        rem_r[k] <= ge ? TW'(part - {1'b0, span_r}) : part[TW-1:0];
        q_r[k]   <= {q_r[k][AXW-2:0], ge};
      end
    end
  end

  always_comb begin
    out_valid = out_valid_r;
    out_res   = out_r;
  end

  assign out_last = out_last_r;

`ifndef ASSERT_OFF
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= CW'(GYRO_QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    w_r <= i_r) else $error("compaction write passed read");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> out_free) else $error("result overwritten while stalled");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_push |-> pc_r < CW'(GYRO_QUEUE_DEPTH)) else $error("push into full queue");
`endif

endmodule
